@@ sv/ldr_pkg.sv @@
`timescale 1ns / 1ps
// shared widths, breakpoint table and payload types for the ldr illuminance converter
// no dependencies

package ldr_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int FS_W       = 13;
	localparam int LUX_W      = 16;
	localparam int FRAC_BITS  = 6;
	localparam int RATIO_W    = FS_W + FRAC_BITS;
	localparam int Q_W        = 16;
	localparam int NUM_W      = 2 * Q_W;
	localparam int ADC_LEVELS = 4096;
	localparam int TABLE_WORDS = 28;
	localparam int NPTS       = TABLE_WORDS / 2;
	localparam int IDX_W      = $clog2(NPTS);

	localparam logic [LUX_W-1:0] LUX_MAX = 16'hFFFF;

	// breakpoints: x is the 10.6 resistance ratio, y is 10.6 lux
	localparam logic [Q_W-1:0] CURVE_X [NPTS] = '{
		16'd0, 16'd21, 16'd64, 16'd106, 16'd192, 16'd448, 16'd960,
		16'd1984, 16'd4032, 16'd8128, 16'd16320, 16'd32704, 16'd65472, 16'd65535
	};
	localparam logic [LUX_W-1:0] CURVE_Y [NPTS] = '{
		16'd0, 16'd3, 16'd13, 16'd26, 16'd60, 16'd202, 16'd599,
		16'd1689, 16'd4652, 16'd12665, 16'd34285, 16'd65535, 16'd65535, 16'd65535
	};

	typedef enum logic [1:0] {
		KIND_CALC   = 2'd0,
		KIND_BRIGHT = 2'd1,
		KIND_DARK   = 2'd2
	} kind_t;

	// result that bypasses the interpolation divider
	typedef struct packed {
		logic             fixed;
		logic [LUX_W-1:0] value;
	} side_t;

endpackage

@@ sv/ldr_div_pipe.sv @@
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per register stage, with sideband
// no dependencies

module ldr_div_pipe #(
	parameter int DIVISOR_W = 12,
	parameter int QUOT_W    = 19,
	parameter int SIDE_W    = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [DIVISOR_W-1:0] rem_in,
	input  logic [QUOT_W-1:0]    low_in,
	input  logic [DIVISOR_W-1:0] divisor_in,
	input  logic [SIDE_W-1:0]    side_in,
	output logic                 out_valid,
	output logic [QUOT_W-1:0]    quotient,
	output logic [SIDE_W-1:0]    side_out
);

	logic                 v_s    [QUOT_W];
	logic [DIVISOR_W-1:0] rem_s  [QUOT_W];
	logic [QUOT_W-1:0]    low_s  [QUOT_W];
	logic [DIVISOR_W-1:0] dvs_s  [QUOT_W];
	logic [SIDE_W-1:0]    side_s [QUOT_W];

	for (genvar j = 0; j < QUOT_W; j++) begin : g_step
		logic                 v_prev;
		logic [DIVISOR_W-1:0] rem_prev;
		logic [QUOT_W-1:0]    low_prev;
		logic [DIVISOR_W-1:0] dvs_prev;
		logic [SIDE_W-1:0]    side_prev;
		logic [DIVISOR_W:0]   trial;
		logic                 fit;

		if (j == 0) begin : g_first
			assign v_prev    = in_valid;
			assign rem_prev  = rem_in;
			assign low_prev  = low_in;
			assign dvs_prev  = divisor_in;
			assign side_prev = side_in;
		end else begin : g_next
			assign v_prev    = v_s[j-1];
			assign rem_prev  = rem_s[j-1];
			assign low_prev  = low_s[j-1];
			assign dvs_prev  = dvs_s[j-1];
			assign side_prev = side_s[j-1];
		end

		// shift in the next dividend bit, subtract when it fits
		assign trial = {rem_prev, low_prev[QUOT_W-1]};
		assign fit   = trial >= {1'b0, dvs_prev};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= fit ? DIVISOR_W'(trial - {1'b0, dvs_prev})
				                 : trial[DIVISOR_W-1:0];
				low_s[j]  <= {low_prev[QUOT_W-2:0], fit};
				dvs_s[j]  <= dvs_prev;
				side_s[j] <= side_prev;
			end
		end
	end

	assign out_valid = v_s[QUOT_W-1];
	assign quotient  = low_s[QUOT_W-1];
	assign side_out  = side_s[QUOT_W-1];

endmodule

@@ sv/ldr_seg_lookup.sv @@
`timescale 1ns / 1ps
// segment search and interpolation numerator, four register stages
// depends on ldr_pkg

module ldr_seg_lookup import ldr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [RATIO_W-1:0] ratio,
	input  kind_t            kind,
	output logic             out_valid,
	output logic [Q_W-1:0]   rem_hi,
	output logic [Q_W-1:0]   num_lo,
	output logic [Q_W-1:0]   span,
	output side_t            side
);

	// stage 1: saturate ratio, find segment
	logic [Q_W-1:0]   q_sat;
	logic [IDX_W-1:0] k_sel;

	logic             v_s1;
	logic [Q_W-1:0]   q_s1;
	logic [IDX_W-1:0] k_s1;
	kind_t            kind_s1;

	assign q_sat = (|ratio[RATIO_W-1:Q_W]) ? {Q_W{1'b1}} : ratio[Q_W-1:0];

	always_comb begin
		k_sel = IDX_W'(NPTS - 1);
		for (int j = NPTS - 1; j >= 1; j--) begin
			if (q_sat <= CURVE_X[j]) begin
				k_sel = IDX_W'(j);
			end
		end
	end

	// stage 2: clamp into segment, form weights
	logic [Q_W-1:0]   x0, x1, qc;
	logic [LUX_W-1:0] y0, y1;
	logic [IDX_W-1:0] k_lo;
	side_t            side_c;

	logic             v_s2;
	logic [Q_W-1:0]   d0_s2, d1_s2, span_s2;
	logic [LUX_W-1:0] y0_s2, y1_s2;
	side_t            side_s2;

	assign k_lo = k_s1 - IDX_W'(1);
	assign x0   = CURVE_X[k_lo];
	assign y0   = CURVE_Y[k_lo];
	assign x1   = CURVE_X[k_s1];
	assign y1   = CURVE_Y[k_s1];
	assign qc   = (q_s1 < x0) ? x0 : ((q_s1 > x1) ? x1 : q_s1);

	always_comb begin
		side_c = '{fixed: 1'b0, value: '0};
		unique case (kind_s1)
			KIND_BRIGHT: side_c = '{fixed: 1'b1, value: LUX_MAX};
			KIND_DARK:   side_c = '{fixed: 1'b1, value: '0};
			default: begin
				// zero-width segment gives the lower y
				if (x1 <= x0) begin
					side_c = '{fixed: 1'b1, value: y0};
				end
			end
		endcase
	end

	// stage 3: products
	logic             v_s3;
	logic [NUM_W-1:0] p0_s3, p1_s3;
	logic [Q_W-1:0]   span_s3;
	side_t            side_s3;

	// stage 4: sum, divider operands
	logic [NUM_W-1:0] num_sum;
	logic             v_s4;
	logic [Q_W-1:0]   rem_s4, low_s4, span_s4;
	side_t            side_s4;

	assign num_sum = NUM_W'({1'b0, p0_s3} + {1'b0, p1_s3});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1    <= q_sat;
			k_s1    <= k_sel;
			kind_s1 <= kind;

			d0_s2   <= qc - x0;
			d1_s2   <= x1 - qc;
			span_s2 <= x1 - x0;
			y0_s2   <= y0;
			y1_s2   <= y1;
			side_s2 <= side_c;

			p0_s3   <= NUM_W'(y0_s2) * NUM_W'(d1_s2);
			p1_s3   <= NUM_W'(y1_s2) * NUM_W'(d0_s2);
			span_s3 <= span_s2;
			side_s3 <= side_s2;

			// bypassed items get a harmless divide by one
			if (side_s3.fixed) begin
				rem_s4  <= '0;
				low_s4  <= '0;
				span_s4 <= Q_W'(1);
			end else begin
				rem_s4  <= num_sum[NUM_W-1:Q_W];
				low_s4  <= num_sum[Q_W-1:0];
				span_s4 <= span_s3;
			end
			side_s4 <= side_s3;
		end
	end

	assign out_valid = v_s4;
	assign rem_hi    = rem_s4;
	assign num_lo    = low_s4;
	assign span      = span_s4;
	assign side      = side_s4;

endmodule

@@ sv/ldr_out_skid.sv @@
`timescale 1ns / 1ps
// two-entry output buffer that decouples the pipeline from the result consumer
// depends on ldr_pkg

module ldr_out_skid import ldr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [LUX_W-1:0] push_data,
	output logic             has_space,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [LUX_W-1:0] out_data
);

	logic [1:0]       cnt_q;
	logic [LUX_W-1:0] head_q, tail_q;
	logic             pop;

	assign pop       = (cnt_q != 2'd0) && out_ready;
	assign has_space = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					head_q <= push_data;
				end else begin
					tail_q <= push_data;
				end
			end
			2'b01: head_q <= tail_q;
			2'b11: begin
				if (cnt_q == 2'd1) begin
					head_q <= push_data;
				end else begin
					head_q <= tail_q;
					tail_q <= push_data;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ sv/ldr_adc_to_illuminance.sv @@
`timescale 1ns / 1ps
// top level of the ldr reading to illuminance converter
// depends on ldr_pkg, ldr_div_pipe, ldr_seg_lookup, ldr_out_skid

// Converts one 12-bit ADC reading of a light-dependent-resistor divider into
// illuminance in unsigned 10.6 fixed point. The reading r gives the ratio
// ((full_scale_count - r) << 6) / r, saturated to 16 bits, which is mapped
// through a fixed 14-point piecewise-linear curve. A reading of zero gives
// 0xFFFF, a reading at or above full_scale_count gives 0. The block takes one
// beat per cycle while the output buffer has room. From an accepted sample to
// its result at the output buffer the pipeline holds one entry stage, 19 stages
// of the ratio divider (one quotient bit each), four stages of segment search,
// clamp, multiply and sum, and 16 stages of the interpolation divider. The two
// dividers set the depth. A two-entry output buffer lets the pipeline keep
// taking samples while a result waits; adc_ready drops only once that buffer
// is full. full_scale_count sits at address 0 of the APB port and resets to
// 4096; it should be written only while no sample is in flight.

module ldr_adc_to_illuminance import ldr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// sample channel
	input  logic                adc_valid,
	output logic                adc_ready,
	input  logic [SAMPLE_W-1:0] adc_sample,
	// result channel
	output logic                lux_valid,
	input  logic                lux_ready,
	output logic [LUX_W-1:0]    illuminance,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// register index lives above the byte offset
	localparam logic REG_FULL_SCALE = 1'b0;

	logic [FS_W-1:0] full_scale_count_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FULL_SCALE) ? {{(32 - FS_W){1'b0}}, full_scale_count_q}
	                                              : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_count_q <= FS_W'(ADC_LEVELS);
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FULL_SCALE)) begin
			full_scale_count_q <= pwdata[FS_W-1:0];
		end
	end

	// the whole pipeline moves together while the output buffer has room
	logic en;
	assign adc_ready = en;

	// entry stage: special cases and ratio dividend
	kind_t           kind_in;
	logic [FS_W-1:0] diff;

	logic                 v_s1;
	kind_t                kind_s1;
	logic [RATIO_W-1:0]   low_s1;
	logic [SAMPLE_W-1:0]  dvs_s1;

	// zero reading wins even when full scale is zero
	always_comb begin
		priority if (adc_sample == '0) begin
			kind_in = KIND_BRIGHT;
		end else if ({1'b0, adc_sample} >= full_scale_count_q) begin
			kind_in = KIND_DARK;
		end else begin
			kind_in = KIND_CALC;
		end
	end

	assign diff = full_scale_count_q - {1'b0, adc_sample};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= adc_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind_in;
			low_s1  <= {diff, {FRAC_BITS{1'b0}}};
			dvs_s1  <= adc_sample;
		end
	end

	// ratio divider
	logic                ratio_valid;
	logic [RATIO_W-1:0]  ratio;
	logic [1:0]          ratio_side;

	ldr_div_pipe #(
		.DIVISOR_W (12),
		.QUOT_W    (19),
		.SIDE_W    (2)
	) u_ratio_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (v_s1),
		.rem_in     ('0),
		.low_in     (low_s1),
		.divisor_in (dvs_s1),
		.side_in    (kind_s1),
		.out_valid  (ratio_valid),
		.quotient   (ratio),
		.side_out   (ratio_side)
	);

	// segment search and numerator
	logic           seg_valid;
	logic [Q_W-1:0] seg_rem_hi, seg_num_lo, seg_span;
	side_t          seg_side;

	ldr_seg_lookup u_seg (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ratio_valid),
		.ratio     (ratio),
		.kind      (kind_t'(ratio_side)),
		.out_valid (seg_valid),
		.rem_hi    (seg_rem_hi),
		.num_lo    (seg_num_lo),
		.span      (seg_span),
		.side      (seg_side)
	);

	// interpolation divider, quotient never exceeds the larger y
	logic              lerp_valid;
	logic [Q_W-1:0]    lerp_q;
	logic [$bits(side_t)-1:0] lerp_side_bits;
	side_t             lerp_side;

	ldr_div_pipe #(
		.DIVISOR_W (16),
		.QUOT_W    (16),
		.SIDE_W    (17)
	) u_lerp_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (seg_valid),
		.rem_in     (seg_rem_hi),
		.low_in     (seg_num_lo),
		.divisor_in (seg_span),
		.side_in    (seg_side),
		.out_valid  (lerp_valid),
		.quotient   (lerp_q),
		.side_out   (lerp_side_bits)
	);

	assign lerp_side = side_t'(lerp_side_bits);

	// pick bypass value or quotient, hand the beat to the output buffer
	logic [LUX_W-1:0] result;
	assign result = lerp_side.fixed ? lerp_side.value : lerp_q;

	ldr_out_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && lerp_valid),
		.push_data (result),
		.has_space (en),
		.out_valid (lux_valid),
		.out_ready (lux_ready),
		.out_data  (illuminance)
	);

endmodule

@@ sv/ldr_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the ldr illuminance converter, bound to the top level
// depends on ldr_adc_to_illuminance

module ldr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        adc_valid,
	input logic        adc_ready,
	input logic        lux_valid,
	input logic        lux_ready,
	input logic [15:0] illuminance,
	input logic [31:0] prdata
);

	// sample side only stalls while results are pending
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!adc_ready |-> lux_valid)
		else $error("sample channel stalled with no result pending");

	// a stall persists until a result beat drains the buffer
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!adc_ready && !(lux_valid && lux_ready)) |=> !adc_ready)
		else $error("sample stall released without a result beat");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(lux_valid && !lux_ready) |=> (lux_valid && $stable(illuminance)))
		else $error("stalled result changed or dropped");

	// full_scale_count is 13 bits, upper read bits stay clear
	a_prdata_width: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:13] == 19'd0)
		else $error("register read shows bits above its width");

endmodule

bind ldr_adc_to_illuminance ldr_checker u_ldr_checker (.*);
